/* design/cfla_pkg.sv */
// ----------------------------------------------------------------------------
// cfla_pkg
// Shared types and field widths for the follower log append block.
// ----------------------------------------------------------------------------
package cfla_pkg;

  localparam int unsigned TermW  = 32;
  localparam int unsigned IndexW = 11;
  localparam int unsigned DataW  = 64;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EVAL
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic apply;
  } cmd_t;

endpackage

/* design/cfla_ctrl.sv */
// ----------------------------------------------------------------------------
// cfla_ctrl
// Two-state sequencer: capture a transaction and start the log read, then
// evaluate, update the log and state, and load the result registers.
// ----------------------------------------------------------------------------
module cfla_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output cfla_pkg::cmd_t    cmd_o
);

  cfla_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfla_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cfla_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = cfla_pkg::ST_EVAL;
        end
      end
      cfla_pkg::ST_EVAL: begin
        state_d = cfla_pkg::ST_IDLE;
      end
      default: begin
        state_d = cfla_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.apply   = 1'b0;
    busy_o        = 1'b0;
    case (state_q)
      cfla_pkg::ST_IDLE: begin
        cmd_o.capture = start_i;
      end
      cfla_pkg::ST_EVAL: begin
        cmd_o.apply = 1'b1;
        busy_o      = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  a_capture_then_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.apply)
    else $error("capture not followed by apply");

  a_apply_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> !cmd_o.apply)
    else $error("apply held for more than one cycle");

endmodule

/* design/cfla_log_mem.sv */
// ----------------------------------------------------------------------------
// cfla_log_mem
// Log store: entry terms with two registered read ports, payloads write only.
// ----------------------------------------------------------------------------
module cfla_log_mem #(
  parameter int unsigned LOG_DEPTH    = 1024,
  parameter int unsigned PAYLOAD_BITS = 64,
  parameter int unsigned AddrW        = $clog2(LOG_DEPTH)
) (
  input  logic                                  clk_i,
  input  logic                                  rd_en_i,
  input  logic [AddrW-1:0]                      rd_addr_a_i,
  input  logic [AddrW-1:0]                      rd_addr_b_i,
  output logic [cfla_pkg::TermW-1:0]            rd_term_a_o,
  output logic [cfla_pkg::TermW-1:0]            rd_term_b_o,
  input  logic                                  wr_en_i,
  input  logic [AddrW-1:0]                      wr_addr_i,
  input  logic [cfla_pkg::TermW-1:0]            wr_term_i,
  input  logic [PAYLOAD_BITS-1:0]               wr_payload_i
);

  logic [cfla_pkg::TermW-1:0] term_mem [LOG_DEPTH];
  logic [PAYLOAD_BITS-1:0]    payload_mem [LOG_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      term_mem[wr_addr_i]    <= wr_term_i;
      payload_mem[wr_addr_i] <= wr_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_term_a_o <= term_mem[rd_addr_a_i];
      rd_term_b_o <= term_mem[rd_addr_b_i];
    end
  end

endmodule

/* design/cfla_dpath.sv */
// ----------------------------------------------------------------------------
// cfla_dpath
// Datapath: transaction registers, log store, term/length/commit state and
// the consistency and append decision.
// ----------------------------------------------------------------------------
module cfla_dpath #(
  parameter int unsigned LOG_DEPTH    = 1024,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cfla_pkg::cmd_t                      cmd_i,
  input  logic [cfla_pkg::TermW-1:0]          msg_term_i,
  input  logic signed [cfla_pkg::IndexW-1:0]  prev_index_i,
  input  logic [cfla_pkg::TermW-1:0]          prev_term_i,
  input  logic signed [cfla_pkg::IndexW-1:0]  leader_commit_i,
  input  logic                                has_entry_i,
  input  logic [cfla_pkg::TermW-1:0]          entry_term_i,
  input  logic [cfla_pkg::DataW-1:0]          entry_payload_i,
  output logic                                done_o,
  output logic [cfla_pkg::TermW-1:0]          resp_term_o,
  output logic                                accepted_o,
  output logic signed [cfla_pkg::IndexW-1:0]  matched_index_o,
  output logic signed [cfla_pkg::IndexW-1:0]  commit_out_o,
  output logic                                stepped_down_o,
  output logic                                log_full_o
);

  localparam int unsigned IW    = cfla_pkg::IndexW;
  localparam int unsigned TW    = cfla_pkg::TermW;
  localparam int unsigned AddrW = $clog2(LOG_DEPTH);
  localparam int unsigned LenW  = $clog2(LOG_DEPTH + 1);
  // compare width: holds any index + 1 and any log length
  localparam int unsigned XW    = (LenW > IW + 1) ? LenW : IW + 1;

  // transaction registers
  logic [TW-1:0]           msg_term_q;
  logic signed [IW-1:0]    prev_index_q;
  logic [TW-1:0]           prev_term_q;
  logic signed [IW-1:0]    leader_commit_q;
  logic                    has_entry_q;
  logic [TW-1:0]           entry_term_q;
  logic [PAYLOAD_BITS-1:0] entry_payload_q;

  // architectural state
  logic [TW-1:0]           cur_term_q;
  logic [LenW-1:0]         log_len_q;
  logic signed [IW-1:0]    commit_q;

  // result registers
  logic                    done_q;
  logic [TW-1:0]           resp_term_q;
  logic                    accepted_q;
  logic signed [IW-1:0]    matched_q;
  logic                    stepped_q;
  logic                    full_q;

  logic [XW-1:0]           prev_in_x;
  logic [XW-1:0]           idx_in_x;
  logic [TW-1:0]           rd_prev_term;
  logic [TW-1:0]           rd_idx_term;

  logic [XW-1:0]           prev_x;
  logic [XW-1:0]           idx_x;
  logic [XW-1:0]           idx_p1_x;
  logic [XW-1:0]           len_x;
  logic                    term_gt;
  logic                    term_lt;
  logic                    prev_none;
  logic                    prev_ok;
  logic                    match_ok;
  logic                    idx_in_log;
  logic                    idx_full;
  logic                    full;
  logic                    do_write;
  logic                    ok;
  logic signed [IW:0]      last_new;
  logic signed [IW:0]      lc_ext;
  logic signed [IW-1:0]    commit_d;
  logic [TW-1:0]           cur_term_d;
  logic [LenW-1:0]         log_len_d;

  // read addresses come straight from the ports in the capture cycle
  assign prev_in_x = {{(XW-IW){prev_index_i[IW-1]}}, prev_index_i};
  assign idx_in_x  = prev_in_x + XW'(1);

  cfla_log_mem #(
    .LOG_DEPTH    (LOG_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_log_mem (
    .clk_i        (clk_i),
    .rd_en_i      (cmd_i.capture),
    .rd_addr_a_i  (prev_in_x[AddrW-1:0]),
    .rd_addr_b_i  (idx_in_x[AddrW-1:0]),
    .rd_term_a_o  (rd_prev_term),
    .rd_term_b_o  (rd_idx_term),
    .wr_en_i      (do_write && cmd_i.apply),
    .wr_addr_i    (idx_x[AddrW-1:0]),
    .wr_term_i    (entry_term_q),
    .wr_payload_i (entry_payload_q)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      msg_term_q      <= msg_term_i;
      prev_index_q    <= prev_index_i;
      prev_term_q     <= prev_term_i;
      leader_commit_q <= leader_commit_i;
      has_entry_q     <= has_entry_i;
      entry_term_q    <= entry_term_i;
      entry_payload_q <= entry_payload_i[PAYLOAD_BITS-1:0];
    end
  end

  always_comb begin
    prev_x     = {{(XW-IW){prev_index_q[IW-1]}}, prev_index_q};
    idx_x      = prev_x + XW'(1);
    idx_p1_x   = idx_x + XW'(1);
    len_x      = XW'(log_len_q);
    term_gt    = msg_term_q > cur_term_q;
    term_lt    = msg_term_q < cur_term_q;
    prev_none  = prev_index_q == '1;
    // index below minus one is a mismatch
    prev_ok    = prev_none ||
                 (!prev_index_q[IW-1] && (prev_x < len_x) && (rd_prev_term == prev_term_q));
    match_ok   = !term_lt && prev_ok;
    idx_in_log = idx_x < len_x;
    idx_full   = idx_x >= XW'(LOG_DEPTH);
    full       = match_ok && has_entry_q && !idx_in_log && idx_full;
    // same-term entry already present: log left as it is
    do_write   = match_ok && has_entry_q &&
                 (idx_in_log ? (rd_idx_term != entry_term_q) : !idx_full);
    ok         = match_ok && !full;
    last_new   = {prev_index_q[IW-1], prev_index_q} + $signed({{IW{1'b0}}, has_entry_q});
    lc_ext     = {leader_commit_q[IW-1], leader_commit_q};

    commit_d = commit_q;
    if (ok && (leader_commit_q > commit_q)) begin
      commit_d = (lc_ext < last_new) ? leader_commit_q : last_new[IW-1:0];
    end
    cur_term_d = term_gt ? msg_term_q : cur_term_q;
    log_len_d  = do_write ? idx_p1_x[LenW-1:0] : log_len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_term_q <= '0;
      log_len_q  <= '0;
      commit_q   <= '1;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.apply;
      if (cmd_i.apply) begin
        cur_term_q <= cur_term_d;
        log_len_q  <= log_len_d;
        commit_q   <= commit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      resp_term_q <= cur_term_d;
      accepted_q  <= ok;
      matched_q   <= ok ? last_new[IW-1:0] : '1;
      stepped_q   <= term_gt;
      full_q      <= full;
    end
  end

  assign done_o          = done_q;
  assign resp_term_o     = resp_term_q;
  assign accepted_o      = accepted_q;
  assign matched_index_o = matched_q;
  assign commit_out_o    = commit_q;
  assign stepped_down_o  = stepped_q;
  assign log_full_o      = full_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(log_len_q) <= XW'(LOG_DEPTH))
    else $error("log length beyond store depth");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.apply) |-> ($stable(commit_q) && $stable(log_len_q) && $stable(cur_term_q)))
    else $error("state changed without a transaction");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && full_q) |-> (!accepted_q && matched_q == '1))
    else $error("full log reported with acceptance");

  a_accept_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && accepted_q) |-> (resp_term_q == msg_term_q))
    else $error("accepted transaction with term other than message term");

  a_term_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_term_q >= $past(cur_term_q))
    else $error("current term decreased");

endmodule

/* design/consensus_follower_log_append.sv */
// start_i in ST_IDLE captures the transaction and issues the log read; in ST_EVAL
//   the datapath applies it, and done_o is registered from that apply strobe
// a start_i that arrives while busy is ignored; busy_o is high for the cycle in
//   which the log term store is read back, checked and written
// reset: current term 0, empty log, commit index -1; the log store itself is
//   not cleared and entries past the log length are never consulted
// ----------------------------------------------------------------------------
// consensus_follower_log_append
// Follower side of an append-entries exchange, at most one entry per transaction.
// ----------------------------------------------------------------------------
module consensus_follower_log_append #(
  parameter int unsigned LOG_DEPTH    = 1024,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [cfla_pkg::TermW-1:0]          msg_term_i,
  input  logic signed [cfla_pkg::IndexW-1:0]  prev_index_i,
  input  logic [cfla_pkg::TermW-1:0]          prev_term_i,
  input  logic signed [cfla_pkg::IndexW-1:0]  leader_commit_i,
  input  logic                                has_entry_i,
  input  logic [cfla_pkg::TermW-1:0]          entry_term_i,
  input  logic [cfla_pkg::DataW-1:0]          entry_payload_i,
  output logic                                done_o,
  output logic [cfla_pkg::TermW-1:0]          resp_term_o,
  output logic                                accepted_o,
  output logic signed [cfla_pkg::IndexW-1:0]  matched_index_o,
  output logic signed [cfla_pkg::IndexW-1:0]  commit_out_o,
  output logic                                stepped_down_o,
  output logic                                log_full_o
);

  cfla_pkg::cmd_t cmd;

  cfla_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  cfla_dpath #(
    .LOG_DEPTH    (LOG_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .msg_term_i      (msg_term_i),
    .prev_index_i    (prev_index_i),
    .prev_term_i     (prev_term_i),
    .leader_commit_i (leader_commit_i),
    .has_entry_i     (has_entry_i),
    .entry_term_i    (entry_term_i),
    .entry_payload_i (entry_payload_i),
    .done_o          (done_o),
    .resp_term_o     (resp_term_o),
    .accepted_o      (accepted_o),
    .matched_index_o (matched_index_o),
    .commit_out_o    (commit_out_o),
    .stepped_down_o  (stepped_down_o),
    .log_full_o      (log_full_o)
  );

endmodule
